[rtl/i2crm_pkg.sv]
// Package with phase, stage and status codes of the I2C register master.
package i2crm_pkg;

  localparam int unsigned MaxReadBytes = 255;

  typedef enum logic [23:0] {
    PH_IDLE  = 24'h000001,
    PH_ST_W  = 24'h000002,
    PH_ST_D1 = 24'h000004,
    PH_ST_D2 = 24'h000008,
    PH_WB_D1 = 24'h000010,
    PH_WB_W  = 24'h000020,
    PH_WB_D2 = 24'h000040,
    PH_WA_D1 = 24'h000080,
    PH_WA_W  = 24'h000100,
    PH_WA_D2 = 24'h000200,
    PH_RB_D1 = 24'h000400,
    PH_RB_W  = 24'h000800,
    PH_RB_D2 = 24'h001000,
    PH_RA_D1 = 24'h002000,
    PH_RA_W  = 24'h004000,
    PH_RA_D2 = 24'h008000,
    PH_SP_D1 = 24'h010000,
    PH_SP_W  = 24'h020000,
    PH_SP_D2 = 24'h040000,
    PH_SP_D3 = 24'h080000,
    PH_RC_W0 = 24'h100000,
    PH_RC_D1 = 24'h200000,
    PH_RC_W1 = 24'h400000,
    PH_RC_D2 = 24'h800000
  } phase_e;

  typedef enum logic [3:0] {
    STG_START1  = 4'd0,
    STG_ADDRW   = 4'd1,
    STG_REG     = 4'd2,
    STG_DATA    = 4'd3,
    STG_START2  = 4'd4,
    STG_ADDRR   = 4'd5,
    STG_READ    = 4'd6,
    STG_STOP    = 4'd7,
    STG_AUTOREC = 4'd8,
    STG_CMDREC  = 4'd9
  } stage_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_NOTREADY = 3'd1,
    ST_NOACK    = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_STUCK    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FN_WRITE   = 2'd0,
    FN_READ    = 2'd1,
    FN_RECOVER = 2'd2,
    FN_BAD     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    CFG_HALF    = 2'd0,
    CFG_TIMEOUT = 2'd1,
    CFG_ADDR    = 2'd2
  } cfg_e;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 24;

  typedef struct packed {
    logic [15:0] half_period;
    logic [23:0] stretch_timeout;
    logic [6:0]  device_address;
  } cfg_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [1:0] func;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       scl;
    logic       sda;
  } item_t;

  typedef struct packed {
    logic       scl_pull_low;
    logic       sda_pull_low;
    logic       busy;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       done;
    logic [2:0] status;
  } result_t;

endpackage

[rtl/i2c_register_master_unit.sv]
// Top level of the I2C register master: configuration, handshakes and result register.
//
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid_i/in_ready_o | cmd, func, reg, data, length, line levels
// out     | output    | out_valid_o/out_ready_i | drives, busy, received byte, done, status
// cfg     | input     | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// While the skid register is empty, one input transfer is taken per cycle; each gives one
// result transfer. The sequencer state advances in the cycle of the input transfer; the
// result sits in a one-entry output register and a skid register behind it.
// Reset clears control state: idle, lines released, bus not ready, default configuration.
// A stalled output holds the input only once both the output and skid registers are full.
module i2c_register_master_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [i2crm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2crm_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       cmd_valid_i,
  input  logic [1:0] func_i,
  input  logic [7:0] reg_addr_i,
  input  logic [7:0] write_data_i,
  input  logic [7:0] read_length_i,
  input  logic       scl_in_i,
  input  logic       sda_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       scl_pull_low_o,
  output logic       sda_pull_low_o,
  output logic       busy_res_o,
  output logic [7:0] rx_byte_o,
  output logic       rx_valid_o,
  output logic       rx_last_o,
  output logic       done_res_o,
  output logic [2:0] status_o
);
  import i2crm_pkg::*;

  cfg_t    cfg_q;
  item_t   item;
  result_t res, out_q, skid_q;
  logic    ov_q, sv_q, step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period     <= 16'd250;
      cfg_q.stretch_timeout <= 24'd50000;
      cfg_q.device_address  <= 7'd104;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_HALF:    cfg_q.half_period <= cfg_data_i[15:0];
        CFG_TIMEOUT: cfg_q.stretch_timeout <= cfg_data_i;
        CFG_ADDR:    cfg_q.device_address <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  assign item = '{cmd_valid: cmd_valid_i, func: func_i, reg_addr: reg_addr_i,
                  write_data: write_data_i, read_length: read_length_i,
                  scl: scl_in_i, sda: sda_in_i};

  assign in_ready_o = !sv_q;
  assign step = in_valid_i && in_ready_o;

  i2crm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (item),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else begin
      if (!ov_q || out_ready_i) begin
        ov_q <= sv_q || step;
        sv_q <= 1'b0;
      end else if (step) begin
        sv_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ov_q || out_ready_i) begin
      out_q <= sv_q ? skid_q : res;
    end
    if (step && ov_q && !out_ready_i) begin
      skid_q <= res;
    end
  end

  assign out_valid_o    = ov_q;
  assign scl_pull_low_o = out_q.scl_pull_low;
  assign sda_pull_low_o = out_q.sda_pull_low;
  assign busy_res_o     = out_q.busy;
  assign rx_byte_o      = out_q.rx_byte;
  assign rx_valid_o     = out_q.rx_valid;
  assign rx_last_o      = out_q.rx_last;
  assign done_res_o     = out_q.done;
  assign status_o       = out_q.status;

  a_skid_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("Skid register full while output register empty.");
  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !out_ready_i && step) |=> sv_q)
    else $error("Result dropped under stall.");
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q && out_ready_i) |=> (ov_q && !sv_q))
    else $error("Skid register did not drain.");

endmodule

[rtl/i2crm_core.sv]
// Per-tick I2C master sequencer: one input item in, one result out.
module i2crm_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  i2crm_pkg::item_t  item_i,
  input  i2crm_pkg::cfg_t   cfg_i,
  output i2crm_pkg::result_t res_o
);
  import i2crm_pkg::*;

  phase_e      phase_q, phase_d;
  stage_e      stage_q, stage_d;
  logic        bus_ready_q, bus_ready_d;
  logic [15:0] half_q, half_d;
  logic [23:0] str_q, str_d;
  logic [3:0]  bit_q, bit_d;
  logic [3:0]  pulse_q, pulse_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  left_q, left_d;
  logic [7:0]  hreg_q, hreg_d;
  logic [7:0]  hdata_q, hdata_d;
  logic [1:0]  hcmd_q, hcmd_d;
  logic [2:0]  err_q, err_d;
  logic        rec_act_q, rec_act_d;
  logic        rec_nest_q, rec_nest_d;
  logic        ack_q, ack_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  result_t     r;

  function automatic logic is_wait(phase_e p);
    return p inside {PH_ST_W, PH_WB_W, PH_WA_W, PH_RB_W, PH_RA_W, PH_SP_W, PH_RC_W0,
                     PH_RC_W1};
  endfunction

  always_comb begin
    logic [15:0] hp;
    logic [7:0]  a;
    logic        go;
    stage_e      ls;
    logic        fin;
    logic [2:0]  fst;
    logic        seqok, seqfail, stopend, recend, stopok, recok, rcchk;
    logic [2:0]  fcode, scode, rcode;
    logic [7:0]  wbv;
    logic        wbl, rbl, spl, rcl, stl;
    logic [7:0]  nl;
    logic [23:0] sinc;

    phase_d = phase_q; stage_d = stage_q; bus_ready_d = bus_ready_q;
    half_d = half_q; str_d = str_q; bit_d = bit_q; pulse_d = pulse_q;
    shift_d = shift_q; left_d = left_q; hreg_d = hreg_q; hdata_d = hdata_q;
    hcmd_d = hcmd_q; err_d = err_q; rec_act_d = rec_act_q;
    rec_nest_d = rec_nest_q; ack_d = ack_q; scl_d = scl_q; sda_d = sda_q;
    r = '0;
    hp = (cfg_i.half_period == 16'd0) ? 16'd1 : cfg_i.half_period;
    a = {cfg_i.device_address, 1'b0};
    go = 1'b0; ls = stage_q; fin = 1'b0; fst = ST_OK;
    seqok = 1'b0; seqfail = 1'b0; stopend = 1'b0; recend = 1'b0;
    stopok = 1'b0; recok = 1'b0; rcchk = 1'b0;
    fcode = ST_OK; scode = ST_OK; rcode = ST_OK;
    wbv = 8'd0; wbl = 1'b0; rbl = 1'b0; spl = 1'b0; rcl = 1'b0; stl = 1'b0;
    nl = 8'd0;
    sinc = str_q + 24'd1;

    if (step_i) begin
      if (phase_q == PH_IDLE) begin
        if (item_i.cmd_valid) begin
          err_d = ST_OK; rec_act_d = 1'b0; rec_nest_d = 1'b0;
          if (item_i.func == FN_RECOVER) begin
            hcmd_d = FN_RECOVER; stage_d = STG_CMDREC; rcl = 1'b1;
          end else if (item_i.func == FN_BAD || !bus_ready_q ||
                       (item_i.func == FN_READ && item_i.read_length == 8'd0)) begin
            fin = 1'b1; fst = ST_NOTREADY;
          end else begin
            hcmd_d = item_i.func; hreg_d = item_i.reg_addr;
            hdata_d = item_i.write_data; left_d = item_i.read_length;
            stage_d = STG_START1; stl = 1'b1;
          end
        end
      end else if (is_wait(phase_q)) begin
        if (item_i.scl) begin
          case (phase_q)
            PH_ST_W: begin
              if (!item_i.sda) begin
                rec_nest_d = 1'b1; rcl = 1'b1;
              end else begin
                phase_d = PH_ST_D1; half_d = hp;
              end
            end
            PH_WB_W: begin phase_d = PH_WB_D2; half_d = hp; end
            PH_WA_W: begin ack_d = !item_i.sda; phase_d = PH_WA_D2; half_d = hp; end
            PH_RB_W: begin
              shift_d = {shift_q[6:0], item_i.sda};
              bit_d = bit_q + 4'd1;
              if (bit_d >= 4'd8) begin
                r.rx_valid = 1'b1; r.rx_byte = shift_d;
                r.rx_last = (left_q <= 8'd1);
              end
              phase_d = PH_RB_D2; half_d = hp;
            end
            PH_RA_W: begin phase_d = PH_RA_D2; half_d = hp; end
            PH_SP_W: begin phase_d = PH_SP_D2; half_d = hp; end
            PH_RC_W0: rcchk = 1'b1;
            default: begin phase_d = PH_RC_D2; half_d = hp; end
          endcase
        end else begin
          str_d = sinc;
          if (sinc >= cfg_i.stretch_timeout) begin
            if (rec_act_q) begin recend = 1'b1; recok = 1'b0; rcode = ST_TIMEOUT; end
            else if (stage_q == STG_STOP) begin
              stopend = 1'b1; stopok = 1'b0; scode = ST_TIMEOUT;
            end else begin seqfail = 1'b1; fcode = ST_TIMEOUT; end
          end
        end
      end else if (half_q > 16'd1) begin
        half_d = half_q - 16'd1;
      end else begin
        half_d = 16'd0;
        case (phase_q)
          PH_ST_D1: begin sda_d = 1'b1; phase_d = PH_ST_D2; half_d = hp; end
          PH_ST_D2: begin scl_d = 1'b1; seqok = 1'b1; end
          PH_WB_D1: begin scl_d = 1'b0; phase_d = PH_WB_W; str_d = '0; end
          PH_WB_D2: begin
            scl_d = 1'b1;
            shift_d = {shift_q[6:0], 1'b0};
            bit_d = bit_q + 4'd1;
            if (bit_d < 4'd8) begin
              sda_d = !shift_d[7]; phase_d = PH_WB_D1;
            end else begin
              sda_d = 1'b0; phase_d = PH_WA_D1;
            end
            half_d = hp;
          end
          PH_WA_D1: begin scl_d = 1'b0; phase_d = PH_WA_W; str_d = '0; end
          PH_WA_D2: begin
            scl_d = 1'b1;
            if (ack_q) seqok = 1'b1;
            else begin seqfail = 1'b1; fcode = ST_NOACK; end
          end
          PH_RB_D1: begin scl_d = 1'b0; phase_d = PH_RB_W; str_d = '0; end
          PH_RB_D2: begin
            scl_d = 1'b1;
            if (bit_q < 4'd8) phase_d = PH_RB_D1;
            else begin sda_d = (left_q > 8'd1); phase_d = PH_RA_D1; end
            half_d = hp;
          end
          PH_RA_D1: begin scl_d = 1'b0; phase_d = PH_RA_W; str_d = '0; end
          PH_RA_D2: begin
            scl_d = 1'b1; sda_d = 1'b0;
            nl = (left_q > 8'd0) ? left_q - 8'd1 : left_q;
            left_d = nl;
            if (nl > 8'd0) rbl = 1'b1;
            else seqok = 1'b1;
          end
          PH_SP_D1: begin scl_d = 1'b0; phase_d = PH_SP_W; str_d = '0; end
          PH_SP_D2: begin sda_d = 1'b0; phase_d = PH_SP_D3; half_d = hp; end
          PH_SP_D3: begin
            if (rec_act_q) begin recend = 1'b1; recok = item_i.sda; rcode = ST_STUCK; end
            else begin stopend = 1'b1; stopok = item_i.sda; scode = ST_STUCK; end
          end
          PH_RC_D1: begin scl_d = 1'b0; phase_d = PH_RC_W1; str_d = '0; end
          PH_RC_D2: begin pulse_d = pulse_q + 4'd1; rcchk = 1'b1; end
          default: begin fin = 1'b1; fst = ST_OK; end
        endcase
      end

      if (rcchk) begin
        if (pulse_d < 4'd9 && !item_i.sda) begin
          scl_d = 1'b1; phase_d = PH_RC_D1; half_d = hp;
        end else spl = 1'b1;
      end

      if (recend) begin
        rec_act_d = 1'b0;
        if (rec_nest_q) begin
          rec_nest_d = 1'b0;
          if (recok) begin
            scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_ST_D1; half_d = hp;
          end else begin seqfail = 1'b1; fcode = rcode; end
        end else if (stage_q == STG_CMDREC) begin
          bus_ready_d = recok; fin = 1'b1; fst = recok ? ST_OK : rcode;
        end else begin
          fin = 1'b1; fst = err_q;
        end
      end

      if (stopend) begin
        if (!stopok && err_q == ST_OK) err_d = scode;
        if (err_d != ST_OK) begin stage_d = STG_AUTOREC; go = 1'b1; ls = STG_AUTOREC; end
        else begin fin = 1'b1; fst = ST_OK; end
      end

      if (seqok) begin
        case (stage_q)
          STG_START1: ls = STG_ADDRW;
          STG_ADDRW:  ls = STG_REG;
          STG_REG:    ls = (hcmd_q == FN_WRITE) ? STG_DATA : STG_START2;
          STG_START2: ls = STG_ADDRR;
          STG_ADDRR:  ls = STG_READ;
          default:    ls = STG_STOP;
        endcase
        stage_d = ls; go = 1'b1;
      end

      if (seqfail) begin
        if (err_q == ST_OK) err_d = fcode;
        stage_d = STG_STOP; ls = STG_STOP; go = 1'b1;
      end

      if (go) begin
        case (ls)
          STG_START1, STG_START2: stl = 1'b1;
          STG_ADDRW: begin wbl = 1'b1; wbv = a; end
          STG_REG:   begin wbl = 1'b1; wbv = hreg_q; end
          STG_DATA:  begin wbl = 1'b1; wbv = hdata_q; end
          STG_ADDRR: begin wbl = 1'b1; wbv = a | 8'd1; end
          STG_READ:  rbl = 1'b1;
          STG_STOP:  spl = 1'b1;
          default:   rcl = 1'b1;
        endcase
      end

      if (stl) begin scl_d = 1'b0; sda_d = 1'b0; phase_d = PH_ST_W; str_d = '0; end
      if (wbl) begin
        shift_d = wbv; bit_d = 4'd0; sda_d = !wbv[7]; phase_d = PH_WB_D1; half_d = hp;
      end
      if (rbl) begin
        shift_d = 8'd0; bit_d = 4'd0; sda_d = 1'b0; phase_d = PH_RB_D1; half_d = hp;
      end
      if (spl) begin sda_d = 1'b1; phase_d = PH_SP_D1; half_d = hp; end
      if (rcl) begin
        rec_act_d = 1'b1; pulse_d = 4'd0; scl_d = 1'b0; sda_d = 1'b0;
        phase_d = PH_RC_W0; str_d = '0;
      end
      if (fin) begin
        phase_d = PH_IDLE; scl_d = 1'b0; sda_d = 1'b0;
        rec_act_d = 1'b0; rec_nest_d = 1'b0; r.done = 1'b1; r.status = fst;
      end
    end
    r.scl_pull_low = scl_d;
    r.sda_pull_low = sda_d;
    r.busy = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE; stage_q <= STG_START1; bus_ready_q <= 1'b0;
      half_q <= '0; str_q <= '0; bit_q <= '0; pulse_q <= '0; shift_q <= '0;
      left_q <= '0; hreg_q <= '0; hdata_q <= '0; hcmd_q <= '0; err_q <= '0;
      rec_act_q <= 1'b0; rec_nest_q <= 1'b0; ack_q <= 1'b0;
      scl_q <= 1'b0; sda_q <= 1'b0;
    end else begin
      phase_q <= phase_d; stage_q <= stage_d; bus_ready_q <= bus_ready_d;
      half_q <= half_d; str_q <= str_d; bit_q <= bit_d; pulse_q <= pulse_d;
      shift_q <= shift_d; left_q <= left_d; hreg_q <= hreg_d; hdata_q <= hdata_d;
      hcmd_q <= hcmd_d; err_q <= err_d; rec_act_q <= rec_act_d;
      rec_nest_q <= rec_nest_d; ack_q <= ack_d; scl_q <= scl_d; sda_q <= sda_d;
    end
  end

  assign res_o = r;

  a_idle_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_IDLE) |-> (!scl_q && !sda_q))
    else $error("Lines driven while idle.");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && r.done) |=> (phase_q == PH_IDLE))
    else $error("Finished command left the block busy.");
  a_nest_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_nest_q |-> rec_act_q)
    else $error("Nested recovery flag without active recovery.");
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !r.done |-> (r.status == ST_OK))
    else $error("Status set without completion.");

endmodule
